// File: sv/ght_pkg.sv
`timescale 1ns / 1ps

package ght_pkg;

    localparam int OPCODE_W  = 2;
    localparam int SLOT_W    = 10;
    localparam int GEN_W     = 16;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 2;

    localparam int SLOTS_DEF      = 1024;
    localparam int GEN_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_SET    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_STALE = 2'd2
    } status_t;

endpackage

// File: sv/ght_req_if.sv
`timescale 1ns / 1ps

interface ght_req_if
    import ght_pkg::*;
;
    logic                 valid;
    logic                 ready;
    opcode_t              opcode;
    logic [SLOT_W-1:0]    slot;
    logic [GEN_W-1:0]     generation;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, output opcode, output slot, output generation,
                    output payload, input ready);
    modport sink   (input valid, input opcode, input slot, input generation,
                    input payload, output ready);
endinterface

// File: sv/ght_rsp_if.sv
`timescale 1ns / 1ps

interface ght_rsp_if
    import ght_pkg::*;
;
    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [SLOT_W-1:0]    handle_slot;
    logic [GEN_W-1:0]     handle_generation;
    logic [PAYLOAD_W-1:0] found_value;

    modport source (output valid, output status, output handle_slot,
                    output handle_generation, output found_value, input ready);
    modport sink   (input valid, input status, input handle_slot,
                    input handle_generation, input found_value, output ready);
endinterface

// File: sv/ght_ram.sv
`timescale 1ns / 1ps

module ght_ram
    import ght_pkg::*;
#(
    parameter int DEPTH = SLOTS_DEF,
    parameter int WIDTH = PAYLOAD_W
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/generational_handle_table_unit.sv
`timescale 1ns / 1ps
// Generational handle table: hands out (slot, generation) handles for stored values.
// Channels: req (sink) carries opcode, slot, generation and payload; rsp (source)
// carries status, handle_slot, handle_generation and found_value. A transaction
// moves when valid and ready are both high; every request gives one response.
// Opcodes: add, lookup, remove, set value by slot. Slot 0 is reserved.
// Flow: a taken request goes to the execute state, which loads the response into
// the output register; an add that pops a recycled slot passes the pop state first.
// Each request must finish before the next is taken; it does one synchronous
// read of the value and generation memories (the popping add first reads the
// free stack) and at most one write back.
// The response sits in an output register, so a new request is taken while a
// response waits; a stalled receiver holds the block only once the next
// response is ready and the output register is still full.
// Reset: a clearing pass zeroes the value and generation memories, one entry a
// cycle with req.ready low; the free stack starts empty and occupancy at one.
module generational_handle_table_unit
    import ght_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int GEN_BITS   = GEN_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ght_req_if.sink   req,
    ght_rsp_if.source rsp
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);
    localparam logic [CW-1:0] SLOTS_C   = CW'(SLOTS);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_EXEC
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           clr_reg, clr_next;
    opcode_t                 op_reg, op_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [GEN_BITS-1:0]     gen_reg, gen_next;
    logic [VALUE_BITS-1:0]   pay_reg, pay_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           free_count_reg, free_count_next;
    logic [CW-1:0]           occ_reg, occ_next;
    logic                    out_valid_reg, out_valid_next;
    status_t                 status_reg, status_next;
    logic [SLOT_W-1:0]       hslot_reg, hslot_next;
    logic [GEN_W-1:0]        hgen_reg, hgen_next;
    logic [PAYLOAD_W-1:0]    found_reg, found_next;

    logic                    val_we, val_re;
    logic [AW-1:0]           val_waddr, val_raddr;
    logic [VALUE_BITS-1:0]   val_wdata, val_rd;
    logic                    gen_we, gen_re;
    logic [AW-1:0]           gen_waddr, gen_raddr;
    logic [GEN_BITS-1:0]     gen_wdata, gen_rd;
    logic                    stk_we, stk_re;
    logic [AW-1:0]           stk_waddr, stk_raddr, stk_wdata, stk_rd;

    logic                    req_fire, req_in_range, slot_in_range;
    logic [AW-1:0]           req_addr, slot_addr;
    logic                    full, live, exec_go;

    ght_ram #(.DEPTH(SLOTS), .WIDTH(VALUE_BITS)) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .re    (val_re),
        .raddr (val_raddr),
        .rdata (val_rd)
    );

    ght_ram #(.DEPTH(SLOTS), .WIDTH(GEN_BITS)) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .re    (gen_re),
        .raddr (gen_raddr),
        .rdata (gen_rd)
    );

    ght_ram #(.DEPTH(SLOTS), .WIDTH(AW)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rd)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && (state_reg == S_IDLE);

    assign req_in_range  = 32'(req.slot) < 32'(SLOTS);
    assign req_addr      = req_in_range ? AW'(req.slot) : '0;
    assign slot_in_range = 32'(slot_reg) < 32'(SLOTS);
    assign slot_addr     = AW'(slot_reg);

    assign full    = occ_reg >= SLOTS_C;
    assign live    = slot_in_range && (val_rd != '0) && (gen_rd == gen_reg);
    assign exec_go = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        gen_next        = gen_reg;
        pay_next        = pay_reg;
        idx_next        = idx_reg;
        free_count_next = free_count_reg;
        occ_next        = occ_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        status_next     = status_reg;
        hslot_next      = hslot_reg;
        hgen_next       = hgen_reg;
        found_next      = found_reg;

        val_we    = 1'b0;
        val_waddr = slot_addr;
        val_wdata = '0;
        val_re    = 1'b0;
        val_raddr = req_addr;
        gen_we    = 1'b0;
        gen_waddr = slot_addr;
        gen_wdata = gen_rd + GEN_BITS'(1);
        gen_re    = 1'b0;
        gen_raddr = req_addr;
        stk_we    = 1'b0;
        stk_waddr = AW'(free_count_reg);
        stk_wdata = slot_addr;
        stk_re    = 1'b0;
        stk_raddr = AW'(free_count_reg - 1'b1);

        case (state_reg)
            S_CLEAR:
            begin
                val_we    = 1'b1;
                val_waddr = clr_reg;
                gen_we    = 1'b1;
                gen_waddr = clr_reg;
                gen_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next    = req.opcode;
                    slot_next  = req.slot;
                    gen_next   = GEN_BITS'(req.generation);
                    pay_next   = VALUE_BITS'(req.payload);
                    val_re     = 1'b1;
                    gen_re     = 1'b1;
                    state_next = S_EXEC;
                    if (req.opcode == OP_ADD && !full)
                    begin
                        if (free_count_reg != '0)
                        begin
                            stk_re     = 1'b1;
                            gen_re     = 1'b0;
                            state_next = S_POP;
                        end
                        else
                        begin
                            gen_raddr = AW'(occ_reg);
                            idx_next  = AW'(occ_reg);
                        end
                    end
                end
            end
            S_POP:
            begin
                gen_re     = 1'b1;
                gen_raddr  = stk_rd;
                idx_next   = stk_rd;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    hslot_next     = '0;
                    hgen_next      = '0;
                    found_next     = '0;
                    state_next     = S_IDLE;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                val_we     = 1'b1;
                                val_waddr  = idx_reg;
                                val_wdata  = pay_reg;
                                occ_next   = occ_reg + 1'b1;
                                hslot_next = SLOT_W'(idx_reg);
                                hgen_next  = GEN_W'(gen_rd);
                                if (free_count_reg != '0)
                                begin
                                    free_count_next = free_count_reg - 1'b1;
                                end
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (live)
                            begin
                                found_next = PAYLOAD_W'(val_rd);
                            end
                            else
                            begin
                                status_next = ST_STALE;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (slot_reg == '0 || !live)
                            begin
                                status_next = ST_STALE;
                            end
                            else
                            begin
                                gen_we     = 1'b1;
                                val_we     = 1'b1;
                                found_next = PAYLOAD_W'(val_rd);
                                if (free_count_reg < SLOTS_C)
                                begin
                                    stk_we          = 1'b1;
                                    free_count_next = free_count_reg + 1'b1;
                                end
                                if (occ_reg > CW'(1))
                                begin
                                    occ_next = occ_reg - 1'b1;
                                end
                            end
                        end
                        OP_SET:
                        begin
                            if (slot_in_range)
                            begin
                                val_we    = 1'b1;
                                val_wdata = pay_reg;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            op_reg         <= OP_ADD;
            slot_reg       <= '0;
            gen_reg        <= '0;
            pay_reg        <= '0;
            idx_reg        <= '0;
            free_count_reg <= '0;
            occ_reg        <= CW'(1);
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            hslot_reg      <= '0;
            hgen_reg       <= '0;
            found_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            op_reg         <= op_next;
            slot_reg       <= slot_next;
            gen_reg        <= gen_next;
            pay_reg        <= pay_next;
            idx_reg        <= idx_next;
            free_count_reg <= free_count_next;
            occ_reg        <= occ_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            hslot_reg      <= hslot_next;
            hgen_reg       <= hgen_next;
            found_reg      <= found_next;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = status_reg;
    assign rsp.handle_slot       = hslot_reg;
    assign rsp.handle_generation = hgen_reg;
    assign rsp.found_value       = found_reg;

endmodule
